[hw/rtl/lcs_pkg.sv]
// lcs_pkg: shared types and constants for the configurable LFSR scrambler.
// Holds the register index codes, the scrambler kind/direction codes and the
// configuration bundle passed from the register bank to the datapath.
`default_nettype none

package lcs_pkg;

    // Shift register and data widths
    localparam int unsigned LFSR_W    = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CELLS_W   = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KIND      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CELLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT      = 3'd4;

    // Scrambler kind and direction codes
    localparam logic KIND_ADDITIVE       = 1'b0;
    localparam logic KIND_MULTIPLICATIVE = 1'b1;
    localparam logic DIR_SCRAMBLE        = 1'b0;
    localparam logic DIR_DESCRAMBLE      = 1'b1;

    // Reset values
    localparam logic [CELLS_W-1:0] NUM_CELLS_RST = 6'd7;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic              kind;
        logic              direction;
        logic [LFSR_W-1:0] fb_mask;     // taps limited to the active cells
        logic [LFSR_W-1:0] init_state;
    } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/lcs_cfg_regs.sv]
// lcs_cfg_regs: configuration register bank of the LFSR scrambler.
// Decodes writes from the plain write port and builds the feedback mask.
// Depends on lcs_pkg.
`default_nettype none

module lcs_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [lcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lcs_pkg::CFG_DAT_W-1:0]  cfg_data,
    output lcs_pkg::cfg_t                       cfg
);

    logic                              kind_reg;
    logic                              direction_reg;
    logic [lcs_pkg::CELLS_W-1:0]       num_cells_reg;
    logic [lcs_pkg::LFSR_W-1:0]        taps_reg;
    logic [lcs_pkg::LFSR_W-1:0]        init_state_reg;
    logic [lcs_pkg::LFSR_W-1:0]        cell_mask;

    // Register writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= lcs_pkg::KIND_ADDITIVE;
            direction_reg  <= lcs_pkg::DIR_SCRAMBLE;
            num_cells_reg  <= lcs_pkg::NUM_CELLS_RST;
            taps_reg       <= '0;
            init_state_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lcs_pkg::REG_KIND:      kind_reg       <= cfg_data[0];
                lcs_pkg::REG_DIRECTION: direction_reg  <= cfg_data[0];
                lcs_pkg::REG_NUM_CELLS: num_cells_reg  <= cfg_data[lcs_pkg::CELLS_W-1:0];
                lcs_pkg::REG_TAPS:      taps_reg       <= cfg_data[lcs_pkg::LFSR_W-1:0];
                lcs_pkg::REG_INIT:      init_state_reg <= cfg_data[lcs_pkg::LFSR_W-1:0];
                default: ;
            endcase
        end
    end

    // Active cells from bit 31 down; zero cells gives no mask, 32 and up give all
    assign cell_mask = ~({lcs_pkg::LFSR_W{1'b1}} >> num_cells_reg);

    assign cfg.kind       = kind_reg;
    assign cfg.direction  = direction_reg;
    assign cfg.fb_mask    = taps_reg & cell_mask;
    assign cfg.init_state = init_state_reg;

endmodule

`default_nettype wire

[hw/rtl/lcs_byte_step.sv]
// lcs_byte_step: combinational eight-bit LFSR step, MSB first.
// Takes the current shift register and one byte, returns the result byte and
// the shift register after the byte. Depends on lcs_pkg.
`default_nettype none

module lcs_byte_step (
    input  wire lcs_pkg::cfg_t                  cfg,
    input  wire logic [lcs_pkg::LFSR_W-1:0]     state_in,
    input  wire logic                           frame_start,
    input  wire logic [lcs_pkg::BYTE_W-1:0]     data_in,
    output logic      [lcs_pkg::BYTE_W-1:0]     data_out,
    output logic      [lcs_pkg::LFSR_W-1:0]     state_out
);

    // Unrolled bit steps
    always_comb
    begin
        logic [lcs_pkg::LFSR_W-1:0] st;
        logic                       din;
        logic                       fb;
        logic                       dout;
        logic                       ent;

        st       = frame_start ? cfg.init_state : state_in;
        data_out = '0;
        for (int k = lcs_pkg::BYTE_W - 1; k >= 0; k--)
        begin
            din  = data_in[k];
            fb   = ^(st & cfg.fb_mask);
            dout = din ^ fb;
            if (cfg.kind == lcs_pkg::KIND_ADDITIVE)
                ent = fb;
            else if (cfg.direction == lcs_pkg::DIR_SCRAMBLE)
                ent = dout;
            else
                ent = din;
            st          = {ent, st[lcs_pkg::LFSR_W-1:1]};
            data_out[k] = dout;
        end
        state_out = st;
    end

endmodule

`default_nettype wire

[hw/rtl/configurable_lfsr_scrambler_unit.sv]
// Configurable LFSR scrambler unit, one byte per beat.
// Usage:
//   Input channel (in_valid/in_stall) carries data_byte, frame_start and
//   frame_end; output channel (out_valid/out_stall) carries out_byte and
//   out_last. A beat moves when valid is high and stall is low.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Path: input register, then result register. Throughput: one byte per
//   cycle while out_stall is low, set by the single 32-bit shift register
//   updated once per byte through eight unrolled steps.
// Stalling: the input register keeps taking beats while the result register
//   is free or being emptied; under a held out_stall one beat waits in the
//   input register and then in_stall rises.
// Reset: both stages empty, shift register cleared, registers at defaults
//   (additive, scramble, 7 cells, taps and initial state zero).
// Depends on lcs_pkg, lcs_cfg_regs and lcs_byte_step.
`default_nettype none

module configurable_lfsr_scrambler_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [lcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lcs_pkg::CFG_DAT_W-1:0]  cfg_data,
    // input beats
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [lcs_pkg::BYTE_W-1:0]     data_byte,
    input  wire logic                           frame_start,
    input  wire logic                           frame_end,
    // output beats
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [lcs_pkg::BYTE_W-1:0]     out_byte,
    output logic                                out_last
);

    lcs_pkg::cfg_t                   cfg;
    logic                            in_vld_reg;
    logic [lcs_pkg::BYTE_W-1:0]      in_byte_reg;
    logic                            in_start_reg;
    logic                            in_end_reg;
    logic                            out_vld_reg;
    logic [lcs_pkg::BYTE_W-1:0]      out_byte_reg;
    logic                            out_last_reg;
    logic [lcs_pkg::LFSR_W-1:0]      shift_reg;
    logic [lcs_pkg::LFSR_W-1:0]      shift_next;
    logic [lcs_pkg::BYTE_W-1:0]      out_byte_next;
    logic                            adv;
    logic                            in_take;

    lcs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lcs_byte_step u_step (
        .cfg         (cfg),
        .state_in    (shift_reg),
        .frame_start (in_start_reg),
        .data_in     (in_byte_reg),
        .data_out    (out_byte_next),
        .state_out   (shift_next)
    );

    // Handshake: input stage moves on when the result register is free or being emptied
    assign adv      = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !adv;
    assign in_take  = in_valid && !in_stall;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_take)
            in_vld_reg <= 1'b1;
        else if (adv)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg  <= data_byte;
            in_start_reg <= frame_start;
            in_end_reg   <= frame_end;
        end
    end

    // Result stage and shift register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            shift_reg   <= '0;
        end
        else
        begin
            if (adv)
            begin
                out_vld_reg <= 1'b1;
                shift_reg   <= shift_next;
            end
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg <= out_byte_next;
            out_last_reg <= in_end_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

`ifndef ASSERT_OFF
    // A byte moved into the result register is presented next cycle
    a_adv_shows: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_vld_reg)
        else $error("result register empty after advance");

    // The LFSR only steps when a byte is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(shift_reg))
        else $error("shift register moved without a byte");

    // A full pipe under a stalled output must hold off the input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && out_vld_reg && out_stall) |-> in_stall)
        else $error("input accepted while pipe full");

    // A pending byte never stays behind an empty result register
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !out_vld_reg) |-> adv)
        else $error("pending byte not advanced");
`endif

endmodule

`default_nettype wire
